// ===== rtl/stepper_step_generator_macros.svh =====
// Assertion macros for the stepper step generator.
`ifndef STEPPER_STEP_GENERATOR_MACROS_SVH
`define STEPPER_STEP_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clk edge outside reset
`define STPG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stpg: assertion failed");
// Next-cycle implication, checked on every clk edge outside reset
`define STPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stpg: assertion failed");
`else
`define STPG_ASSERT_IMPL(label, ante, cons)
`define STPG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/stpg_pkg.sv =====
// Shared types, codes and constants of the stepper step generator.
package stpg_pkg;

  // operation codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_RAMP = 2'd2;

  // active mode codes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_POS   = 2'd1;
  localparam logic [1:0] MODE_SPEED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HALF_TURN  = 2'd0;
  localparam logic [1:0] REG_HOME_LEFT  = 2'd1;
  localparam logic [1:0] REG_HOME_RIGHT = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE   = 2'd3;

  // reset values and widths
  localparam logic [13:0] HALF_TURN_RESET = 14'd768;
  localparam logic [7:0]  DEBOUNCE_RESET  = 8'd200;
  localparam int ACCUM_BITS_DEFAULT = 32;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int IN_TDATA_W   = 104;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 72;

  // one input word
  typedef struct packed {
    logic [1:0]  operation;
    logic        home_sensor;
    logic [31:0] target_steps;
    logic [31:0] speed_value;
    logic [31:0] accel_value;
  } item_t;

  // one result word
  typedef struct packed {
    logic        step_pulse;
    logic        direction;
    logic        awake;
    logic [15:0] wrapped_position;
    logic [15:0] revolutions;
    logic        home_fault;
    logic [1:0]  active_mode;
    logic [31:0] velocity_now;
  } result_t;

  // configuration registers
  typedef struct packed {
    logic [13:0] half_turn_steps;
    logic [15:0] home_left_position;
    logic [15:0] home_right_position;
    logic [7:0]  debounce_limit;
  } cfg_t;

  // step detector status
  typedef struct packed {
    logic pulse;
    logic fwd;
  } step_t;

  // debounced home edge
  typedef struct packed {
    logic accept;
    logic level;
  } home_evt_t;

endpackage

// ===== rtl/stpg_phase.sv =====
// Phase accumulator and step detection.
module stpg_phase import stpg_pkg::*; #(
  parameter int ACCUM_BITS = ACCUM_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [31:0] velocity,
  output step_t       step
);

  logic [ACCUM_BITS-1:0] phase;
  logic [ACCUM_BITS-1:0] phase_next;
  logic [63:0]           vext64;

  // sign-extend velocity to the accumulator width and add
  assign vext64     = {{32{velocity[31]}}, velocity};
  assign phase_next = phase + vext64[ACCUM_BITS-1:0];

  // a step fires when the signed accumulator wraps in the travel direction
  always_comb begin
    step.fwd = !velocity[31] && (velocity != 32'd0);
    if (step.fwd) begin
      step.pulse = $signed(phase_next) < $signed(phase);
    end else begin
      step.pulse = $signed(phase_next) > $signed(phase);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (tick) begin
      phase <= phase_next;
    end
  end

endmodule

// ===== rtl/stpg_home.sv =====
// Home sensor debounce and edge acceptance.
module stpg_home import stpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic       level,
  input  logic [7:0] debounce_limit,
  output home_evt_t  evt
);

  logic       home_level;
  logic [7:0] debounce_count;
  logic [8:0] count_inc;
  logic       same;

  // count before saturation decides acceptance
  assign same       = (level == home_level);
  assign count_inc  = {1'b0, debounce_count} + 9'd1;
  assign evt.accept = !same && (count_inc > {1'b0, debounce_limit});
  assign evt.level  = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      home_level     <= 1'b0;
      debounce_count <= 8'd0;
    end else if (tick) begin
      if (same) begin
        debounce_count <= 8'd0;
      end else begin
        debounce_count <= count_inc[8] ? 8'hFF : count_inc[7:0];
      end
      if (evt.accept) begin
        home_level <= level;
      end
    end
  end

endmodule

// ===== rtl/stpg_motion.sv =====
// Motion state: velocity, modes, step counting, turn position and calibration.
`include "stepper_step_generator_macros.svh"
module stpg_motion import stpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  step_t       step,
  input  home_evt_t   evt,
  input  cfg_t        cfg,
  output logic [31:0] velocity,
  output result_t     res
);

  logic [31:0] acceleration;
  logic [31:0] goal_steps;
  logic [31:0] goal_speed;
  logic [31:0] goal_velocity;
  logic [31:0] ramp_rate;
  logic [31:0] move_count;
  logic [1:0]  mode;
  logic [15:0] turn_position;
  logic [15:0] turn_count;
  logic        fault_flag;
  logic        enabled;

  logic [31:0] velocity_next;
  logic [31:0] acceleration_next;
  logic [31:0] goal_steps_next;
  logic [31:0] goal_speed_next;
  logic [31:0] goal_velocity_next;
  logic [31:0] ramp_rate_next;
  logic [31:0] move_count_next;
  logic [1:0]  mode_next;
  logic [15:0] turn_position_next;
  logic [15:0] turn_count_next;
  logic        fault_flag_next;
  logic        enabled_next;

  logic [31:0] vel_acc;
  logic [32:0] dv;
  logic [32:0] rate33;
  logic [32:0] neg_rate33;
  logic [15:0] half16;
  logic [15:0] neg_half16;
  logic        vel_pos;

  // fixed terms of this item
  assign vel_acc    = velocity + acceleration;
  assign dv         = {goal_velocity[31], goal_velocity} - {vel_acc[31], vel_acc};
  assign rate33     = {ramp_rate[31], ramp_rate};
  assign neg_rate33 = 33'd0 - rate33;
  assign half16     = {2'b00, cfg.half_turn_steps};
  assign neg_half16 = 16'd0 - half16;

  // next state for the item in flight
  always_comb begin
    velocity_next      = velocity;
    acceleration_next  = acceleration;
    goal_steps_next    = goal_steps;
    goal_speed_next    = goal_speed;
    goal_velocity_next = goal_velocity;
    ramp_rate_next     = ramp_rate;
    move_count_next    = move_count;
    mode_next          = mode;
    turn_position_next = turn_position;
    turn_count_next    = turn_count;
    fault_flag_next    = fault_flag;
    enabled_next       = enabled;
    vel_pos            = 1'b0;
    unique case (item.operation)
      OP_TICK: begin
        // step bookkeeping
        if (step.pulse) begin
          if (step.fwd) begin
            move_count_next = move_count + 32'd1;
            if ($signed(turn_position) >= $signed(half16)) begin
              turn_position_next = neg_half16;
              turn_count_next    = turn_count + 16'd1;
            end else begin
              turn_position_next = turn_position + 16'd1;
            end
          end else begin
            move_count_next = move_count - 32'd1;
            if ($signed(turn_position) <= $signed(neg_half16)) begin
              turn_position_next = half16;
              turn_count_next    = turn_count - 16'd1;
            end else begin
              turn_position_next = turn_position - 16'd1;
            end
          end
        end
        velocity_next = vel_acc;
        // active mode
        unique case (mode)
          MODE_POS: begin
            if ($signed(goal_steps) > $signed(move_count_next)) begin
              velocity_next = goal_speed;
            end else if ($signed(goal_steps) < $signed(move_count_next)) begin
              velocity_next = 32'd0 - goal_speed;
            end else begin
              velocity_next = 32'd0;
              mode_next     = MODE_NONE;
              enabled_next  = 1'b0;
            end
          end
          MODE_SPEED: begin
            if ($signed(dv) > $signed(rate33)) begin
              acceleration_next = ramp_rate;
            end else if ($signed(dv) < $signed(neg_rate33)) begin
              acceleration_next = 32'd0 - ramp_rate;
            end else begin
              acceleration_next = 32'd0;
              velocity_next     = goal_velocity;
              mode_next         = MODE_NONE;
              if (goal_velocity == 32'd0) begin
                enabled_next = 1'b0;
              end
            end
          end
          default: ;
        endcase
        // home edge: fault when stopped, else calibrate
        vel_pos = !velocity_next[31] && (velocity_next != 32'd0);
        if (evt.accept) begin
          if (velocity_next == 32'd0) begin
            fault_flag_next = 1'b1;
          end else if (evt.level == vel_pos) begin
            turn_position_next = cfg.home_left_position;
          end else begin
            turn_position_next = cfg.home_right_position;
          end
        end
      end
      OP_MOVE: begin
        enabled_next    = 1'b1;
        goal_steps_next = item.target_steps;
        goal_speed_next = item.speed_value;
        move_count_next = 32'd0;
        mode_next       = MODE_POS;
      end
      OP_RAMP: begin
        enabled_next       = 1'b1;
        goal_velocity_next = item.speed_value;
        ramp_rate_next     = item.accel_value;
        move_count_next    = 32'd0;
        mode_next          = MODE_SPEED;
      end
      default: ;
    endcase
  end

  // result word of the item in flight
  always_comb begin
    res.step_pulse       = (item.operation == OP_TICK) && step.pulse;
    res.direction        = step.fwd;
    res.awake            = enabled_next;
    res.wrapped_position = turn_position_next;
    res.revolutions      = turn_count_next;
    res.home_fault       = fault_flag_next;
    res.active_mode      = mode_next;
    res.velocity_now     = velocity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity      <= '0;
      acceleration  <= '0;
      goal_steps    <= '0;
      goal_speed    <= '0;
      goal_velocity <= '0;
      ramp_rate     <= '0;
      move_count    <= '0;
      mode          <= MODE_NONE;
      turn_position <= '0;
      turn_count    <= '0;
      fault_flag    <= 1'b0;
      enabled       <= 1'b0;
    end else if (fire) begin
      velocity      <= velocity_next;
      acceleration  <= acceleration_next;
      goal_steps    <= goal_steps_next;
      goal_speed    <= goal_speed_next;
      goal_velocity <= goal_velocity_next;
      ramp_rate     <= ramp_rate_next;
      move_count    <= move_count_next;
      mode          <= mode_next;
      turn_position <= turn_position_next;
      turn_count    <= turn_count_next;
      fault_flag    <= fault_flag_next;
      enabled       <= enabled_next;
    end
  end

  // a mode never runs with the driver asleep; the fault flag is sticky
  `STPG_ASSERT_IMPL(a_mode_awake, mode != MODE_NONE, enabled)
  `STPG_ASSERT_NEXT(a_fault_sticky, fault_flag, fault_flag)

endmodule

// ===== rtl/stepper_step_generator.sv =====
// Top level of the stepper step generator: handshake, configuration, result register.
// A word in the input register is processed into the result register once that register is free.
// Throughput: one word per cycle while m_tready keeps taking results; state advances in one
// pass of add/compare logic between the input register and the result register.
// While a result waits on m_tready the input register holds at most one word, then s_tready drops.
// Synchronous active-high rst clears the valid flags and the motion, phase and debounce state,
// selects no mode, puts the driver asleep and loads the configuration reset values.
`include "stepper_step_generator_macros.svh"
module stepper_step_generator import stpg_pkg::*; #(
  parameter int ACCUM_BITS = ACCUM_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // home_sensor[0], target_steps[32:1], speed_value[64:33], accel_value[96:65]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // operation[1:0]
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // step_pulse[0], direction[1], awake[2], wrapped_position[18:3],
  // revolutions[34:19], home_fault[35], active_mode[37:36], velocity_now[69:38]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  item_t     in_item;
  logic      in_valid;
  result_t   out_res;
  logic      out_valid;
  logic      adv;
  logic      tick;
  cfg_t      cfg;
  step_t     step;
  home_evt_t evt;
  result_t   res;
  logic [31:0] velocity;

  // handshake: process the held word when the result register is free
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;
  assign tick     = adv && (in_item.operation == OP_TICK);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.operation    <= s_tuser[1:0];
      in_item.home_sensor  <= s_tdata[0];
      in_item.target_steps <= s_tdata[32:1];
      in_item.speed_value  <= s_tdata[64:33];
      in_item.accel_value  <= s_tdata[96:65];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_turn_steps     <= HALF_TURN_RESET;
      cfg.home_left_position  <= '0;
      cfg.home_right_position <= '0;
      cfg.debounce_limit      <= DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_HALF_TURN:  cfg.half_turn_steps     <= cfg_wdata[13:0];
        REG_HOME_LEFT:  cfg.home_left_position  <= cfg_wdata;
        REG_HOME_RIGHT: cfg.home_right_position <= cfg_wdata;
        REG_DEBOUNCE:   cfg.debounce_limit      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  stpg_phase #(
    .ACCUM_BITS(ACCUM_BITS)
  ) u_phase (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick),
    .velocity (velocity),
    .step     (step)
  );

  stpg_home u_home (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .level          (in_item.home_sensor),
    .debounce_limit (cfg.debounce_limit),
    .evt            (evt)
  );

  stpg_motion u_motion (
    .clk      (clk),
    .rst      (rst),
    .fire     (adv),
    .item     (in_item),
    .step     (step),
    .evt      (evt),
    .cfg      (cfg),
    .velocity (velocity),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.velocity_now, out_res.active_mode, out_res.home_fault,
                     out_res.revolutions, out_res.wrapped_position, out_res.awake,
                     out_res.direction, out_res.step_pulse};

  // a processed word shows up as a result; a held word is never dropped
  `STPG_ASSERT_NEXT(a_adv_result, adv, m_tvalid)
  `STPG_ASSERT_NEXT(a_in_hold, in_valid && !adv, in_valid)

endmodule
